### hw/rtl/tspa_pkg.sv
// Shared types and constants of the program association section parser.
package tspa_pkg;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_TABLE = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4
    } status_t;

    localparam logic [15:0] MIN_BUFFER_LEN    = 16'd8;
    localparam logic [12:0] MIN_SECTION_TOTAL = 13'd12;
    localparam logic [12:0] IDX_TABLE_ID      = 13'd0;
    localparam logic [12:0] IDX_LEN_HI        = 13'd1;
    localparam logic [12:0] IDX_LEN_LO        = 13'd2;
    localparam logic [12:0] IDX_VERSION       = 13'd5;
    localparam logic [12:0] IDX_ENTRY_START   = 13'd8;
    localparam logic [1:0]  ENTRY_LAST_BYTE   = 2'd3;

    typedef struct packed {
        logic        is_lookup;
        logic        first;
        logic [7:0]  data;
        logic [15:0] blen;
        logic        blen_short;
        logic [15:0] pn;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [12:0] consumed;
        logic [15:0] stream_id;
        logic [4:0]  version;
        logic [4:0]  count;
        logic [12:0] pid;
        logic        full;
    } res_t;

endpackage

### hw/rtl/tspa_front.sv
// Front end: accepts input transactions, classifies them and queues them for execution.
module tspa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            kind,
    input  logic            first_byte,
    input  logic [7:0]      data_byte,
    input  logic [15:0]     buffer_length,
    input  logic [15:0]     program_number,
    output logic            cmd_valid,
    output tspa_pkg::cmd_t  cmd,
    input  logic            cmd_take
);
    import tspa_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       in_fire;
    logic       out_fire;
    cmd_t       in_cmd;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign in_fire   = push && !full;
    assign out_fire  = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.is_lookup  = kind;
        in_cmd.first      = first_byte;
        in_cmd.data       = data_byte;
        in_cmd.blen       = buffer_length;
        in_cmd.blen_short = (buffer_length < MIN_BUFFER_LEN);
        in_cmd.pn         = program_number;
    end

    always_comb
    begin
        wr_ptr_next = in_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_fire ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, in_fire} - {1'b0, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### hw/rtl/tspa_back.sv
// Back end: section state, program table, lookups and the result queue.
module tspa_back #(
    parameter int MAX_PROGRAMS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  tspa_pkg::cmd_t  cmd,
    output logic            cmd_take,
    output logic            empty,
    input  logic            pop,
    output tspa_pkg::res_t  res_out
);
    import tspa_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROGRAMS + 1);
    localparam int IDX_W = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;

    logic [12:0]      idx_reg,    idx_next;
    logic [11:0]      slen_reg,   slen_next;
    logic             skip_reg,   skip_next;
    logic [15:0]      sid_reg,    sid_next;
    logic [4:0]       ver_reg,    ver_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [23:0]      shift_reg,  shift_next;
    logic             drop_reg,   drop_next;

    logic [15:0]      pn_tab  [MAX_PROGRAMS];
    logic [12:0]      pid_tab [MAX_PROGRAMS];

    logic             wr_pn_en;
    logic             wr_pid_en;
    logic [IDX_W-1:0] wr_idx;

    logic             lk_hit;
    logic [12:0]      lk_pid;
    logic             pid_hit;
    logic [IDX_W-1:0] pid_idx;

    logic [12:0]      eff_idx;
    logic [11:0]      eff_slen;
    logic             eff_skip;
    logic [23:0]      eff_shift;
    logic             eff_drop;
    logic [11:0]      slen_w;
    logic [15:0]      entry_pn;
    logic [12:0]      entry_pid;
    logic             err;
    status_t          err_status;
    logic [4:0]       new_ver;
    logic [CNT_W+4:0] count_ext;

    res_t             res;
    logic             res_push;

    res_t             oq_reg [2];
    logic             owr_reg, owr_next;
    logic             ord_reg, ord_next;
    logic [1:0]       ocnt_reg, ocnt_next;
    logic             pop_fire;

    assign cmd_take  = cmd_valid && (ocnt_reg != 2'd2);
    assign entry_pn  = eff_shift[23:8];
    assign entry_pid = {eff_shift[4:0], cmd.data};

    always_comb
    begin
        lk_hit  = 1'b0;
        lk_pid  = 13'd0;
        pid_hit = 1'b0;
        pid_idx = '0;
        for (int i = MAX_PROGRAMS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < count_reg) && (pn_tab[i] == cmd.pn))
            begin
                lk_hit = 1'b1;
                lk_pid = pid_tab[i];
            end
            if ((CNT_W'(i) < count_reg) && (pid_tab[i] == entry_pid))
            begin
                pid_hit = 1'b1;
                pid_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        slen_next  = slen_reg;
        skip_next  = skip_reg;
        sid_next   = sid_reg;
        ver_next   = ver_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        drop_next  = drop_reg;
        wr_pn_en   = 1'b0;
        wr_pid_en  = 1'b0;
        wr_idx     = count_reg[IDX_W-1:0];
        res_push   = 1'b0;
        err        = 1'b0;
        err_status = ST_BAD_LEN;
        new_ver    = cmd.data[5:1];
        eff_idx    = cmd.first ? 13'd0 : idx_reg;
        eff_slen   = cmd.first ? 12'd0 : slen_reg;
        eff_skip   = cmd.first ? 1'b0 : skip_reg;
        eff_shift  = cmd.first ? 24'd0 : shift_reg;
        eff_drop   = cmd.first ? 1'b0 : drop_reg;
        slen_w     = eff_slen;
        res.status   = ST_MISS;
        res.consumed = 13'd0;
        res.pid      = 13'd0;
        res.full     = 1'b0;

        if (cmd_take)
        begin
            if (cmd.is_lookup)
            begin
                res_push   = 1'b1;
                res.status = lk_hit ? ST_HIT : ST_MISS;
                res.pid    = lk_hit ? lk_pid : 13'd0;
            end
            else
            begin
                idx_next   = eff_idx;
                slen_next  = eff_slen;
                skip_next  = eff_skip;
                shift_next = eff_shift;
                drop_next  = eff_drop;
                if (!eff_skip)
                begin
                    if (eff_idx == IDX_TABLE_ID)
                    begin
                        if (cmd.blen_short)
                        begin
                            err        = 1'b1;
                            err_status = ST_BAD_LEN;
                        end
                        else if (cmd.data != 8'd0)
                        begin
                            err        = 1'b1;
                            err_status = ST_BAD_TABLE;
                        end
                    end
                    else if (eff_idx == IDX_LEN_HI)
                    begin
                        slen_w    = {cmd.data[3:0], 8'h00};
                        slen_next = slen_w;
                    end
                    else if (eff_idx == IDX_LEN_LO)
                    begin
                        slen_w    = eff_slen | {4'h0, cmd.data};
                        slen_next = slen_w;
                        if ((({1'b0, slen_w} + 13'd3) < MIN_SECTION_TOTAL)
                            || (({4'h0, slen_w} + 16'd3) > cmd.blen))
                        begin
                            err        = 1'b1;
                            err_status = ST_BAD_LEN;
                        end
                    end
                    else if (eff_idx == IDX_VERSION)
                    begin
                        if (new_ver != ver_reg)
                        begin
                            count_next = '0;
                        end
                        sid_next = eff_shift[15:0];
                        ver_next = new_ver;
                    end
                    else if ((eff_idx >= IDX_ENTRY_START)
                             && (eff_idx[1:0] == ENTRY_LAST_BYTE)
                             && (({1'b0, eff_idx} + 14'd2) <= {2'b00, eff_slen}))
                    begin
                        if (entry_pn != 16'd0)
                        begin
                            if (pid_hit)
                            begin
                                wr_pn_en = 1'b1;
                                wr_idx   = pid_idx;
                            end
                            else if (count_reg < CNT_W'(MAX_PROGRAMS))
                            begin
                                wr_pn_en   = 1'b1;
                                wr_pid_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                    end

                    if (err)
                    begin
                        skip_next  = 1'b1;
                        res_push   = 1'b1;
                        res.status = err_status;
                        res.full   = eff_drop;
                    end
                    else
                    begin
                        shift_next = {eff_shift[15:0], cmd.data};
                        if ((eff_idx >= IDX_ENTRY_START)
                            && ({1'b0, eff_idx} == ({2'b00, slen_w} + 14'd2)))
                        begin
                            skip_next    = 1'b1;
                            res_push     = 1'b1;
                            res.status   = ST_DONE;
                            res.consumed = {1'b0, slen_w} + 13'd3;
                            res.full     = drop_next;
                        end
                        else
                        begin
                            idx_next = eff_idx + 13'd1;
                        end
                    end
                end
            end
        end

        count_ext     = {5'd0, count_next};
        res.stream_id = sid_next;
        res.version   = ver_next;
        res.count     = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 13'd0;
            slen_reg  <= 12'd0;
            skip_reg  <= 1'b1;
            sid_reg   <= 16'd0;
            ver_reg   <= 5'd0;
            count_reg <= '0;
            shift_reg <= 24'd0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            slen_reg  <= slen_next;
            skip_reg  <= skip_next;
            sid_reg   <= sid_next;
            ver_reg   <= ver_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_pn_en)
        begin
            pn_tab[wr_idx] <= entry_pn;
        end
        if (wr_pid_en)
        begin
            pid_tab[wr_idx] <= entry_pid;
        end
    end

    assign pop_fire = pop && (ocnt_reg != 2'd0);
    assign empty    = (ocnt_reg == 2'd0);
    assign res_out  = oq_reg[ord_reg];

    always_comb
    begin
        owr_next  = res_push ? !owr_reg : owr_reg;
        ord_next  = pop_fire ? !ord_reg : ord_reg;
        ocnt_next = ocnt_reg + {1'b0, res_push} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            owr_reg  <= owr_next;
            ord_reg  <= ord_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            oq_reg[owr_reg] <= res;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROGRAMS))
        else $error("program count exceeds table size");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 2'd2)
        else $error("result queue overflow");

    a_lookup_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.is_lookup) |=> ($stable(count_reg) && $stable(idx_reg)))
        else $error("lookup disturbed section state");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drop_reg) |-> (count_reg == CNT_W'(MAX_PROGRAMS)))
        else $error("entry dropped while table had room");

    a_take_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (ocnt_reg != 2'd2))
        else $error("result produced with no room in queue");

endmodule

### hw/rtl/ts_program_association_parser_core.sv
// Top level of the transport stream program association section parser.
// Each input transaction is a section byte or a program number lookup, and the block
// accepts one every clock cycle as long as results are popped. A transaction first waits
// in a two-entry input queue, then the execution stage handles it combinationally, with
// the program table compared against all entries in parallel, and any result is registered
// into a two-entry result queue, from which it appears on the result ports. Section bytes
// that produce no result simply update the parser state.
module ts_program_association_parser_core #(
    parameter int MAX_PROGRAMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic        first_byte,
    input  logic [7:0]  data_byte,
    input  logic [15:0] buffer_length,
    input  logic [15:0] program_number,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [12:0] consumed_length,
    output logic [15:0] stream_id,
    output logic [4:0]  version,
    output logic [4:0]  program_count,
    output logic [12:0] found_pid,
    output logic        table_full
);
    import tspa_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;
    res_t res;

    tspa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .first_byte     (first_byte),
        .data_byte      (data_byte),
        .buffer_length  (buffer_length),
        .program_number (program_number),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    tspa_back #(
        .MAX_PROGRAMS (MAX_PROGRAMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res_out   (res)
    );

    assign status          = res.status;
    assign consumed_length = res.consumed;
    assign stream_id       = res.stream_id;
    assign version         = res.version;
    assign program_count   = res.count;
    assign found_pid       = res.pid;
    assign table_full      = res.full;

endmodule

### verif/ts_program_association_parser_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the program association section parser core.
module ts_program_association_parser_core_test;
    import tspa_pkg::*;

    localparam int MAX_PROGRAMS = 16;
    localparam int STALL_LIMIT  = 2000;

    typedef logic [7:0] octet_q[$];
    typedef struct packed {
        logic [15:0] pn;
        logic [12:0] pid;
    } program_t;
    typedef program_t program_q[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push;
    logic        full;
    logic        kind;
    logic        first_byte;
    logic [7:0]  data_byte;
    logic [15:0] buffer_length;
    logic [15:0] program_number;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [12:0] consumed_length;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic [4:0]  program_count;
    logic [12:0] found_pid;
    logic        table_full;

    // Mirror of the parser state.
    logic [12:0] byte_idx = '0;
    logic [11:0] sec_len = '0;
    bit          skipping = 1'b1;
    logic [15:0] ts_id = '0;
    logic [4:0]  ver_q = '0;
    logic [4:0]  n_progs = '0;
    logic [23:0] shift_q = '0;
    logic [15:0] pn_tab[MAX_PROGRAMS];
    logic [12:0] pid_tab[MAX_PROGRAMS];
    bit          dropped = 1'b0;

    res_t pat_reports_due[$];
    int   live_items = 0;
    int   reports_made = 0;
    int   mismatches = 0;
    int   send_quiet = 0;
    int   recv_quiet = 0;
    int   backlog_hold = 0;
    bit   sender_eager = 1'b0;
    int   stall_cycles = 0;

    ts_program_association_parser_core #(.MAX_PROGRAMS(MAX_PROGRAMS)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .first_byte      (first_byte),
        .data_byte       (data_byte),
        .buffer_length   (buffer_length),
        .program_number  (program_number),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .consumed_length (consumed_length),
        .stream_id       (stream_id),
        .version         (version),
        .program_count   (program_count),
        .found_pid       (found_pid),
        .table_full      (table_full)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1, 2: return $urandom_range(0, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic void queue_report(status_t st, logic [12:0] consumed, logic [12:0] pid,
                                         logic full_flag);
        res_t r;
        r.status    = st;
        r.consumed  = consumed;
        r.stream_id = ts_id;
        r.version   = ver_q;
        r.count     = n_progs;
        r.pid       = pid;
        r.full      = full_flag;
        pat_reports_due.push_back(r);
        reports_made++;
    endfunction

    function automatic void store_program(logic [15:0] pn, logic [12:0] pid);
        int i;
        if (pn == 16'd0)
            return;
        for (i = 0; i < int'(n_progs); i++)
        begin
            if (pid_tab[i] == pid)
            begin
                pn_tab[i] = pn;
                return;
            end
        end
        if (int'(n_progs) < MAX_PROGRAMS)
        begin
            pn_tab[n_progs]  = pn;
            pid_tab[n_progs] = pid;
            n_progs++;
        end
        else
            dropped = 1'b1;
    endfunction

    function automatic void mirror_transaction(logic k, logic f, logic [7:0] b, logic [15:0] bl,
                                               logic [15:0] pn);
        int idx;
        int i;
        if (k)
        begin
            live_items++;
            for (i = 0; i < int'(n_progs); i++)
            begin
                if (pn_tab[i] == pn)
                begin
                    queue_report(ST_HIT, '0, pid_tab[i], 1'b0);
                    return;
                end
            end
            queue_report(ST_MISS, '0, '0, 1'b0);
            return;
        end
        if (f)
        begin
            byte_idx = '0;
            sec_len  = '0;
            skipping = 1'b0;
            shift_q  = '0;
            dropped  = 1'b0;
        end
        if (skipping)
            return;
        live_items++;
        idx = int'(byte_idx);
        if (idx == int'(IDX_TABLE_ID))
        begin
            if (bl < MIN_BUFFER_LEN)
            begin
                skipping = 1'b1;
                queue_report(ST_BAD_LEN, '0, '0, dropped);
                return;
            end
            if (b != 8'd0)
            begin
                skipping = 1'b1;
                queue_report(ST_BAD_TABLE, '0, '0, dropped);
                return;
            end
        end
        else if (idx == int'(IDX_LEN_HI))
            sec_len = {b[3:0], 8'h00};
        else if (idx == int'(IDX_LEN_LO))
        begin
            sec_len = sec_len | {4'h0, b};
            if (int'(sec_len) + 3 < int'(MIN_SECTION_TOTAL) || int'(sec_len) + 3 > int'(bl))
            begin
                skipping = 1'b1;
                queue_report(ST_BAD_LEN, '0, '0, dropped);
                return;
            end
        end
        else if (idx == int'(IDX_VERSION))
        begin
            if (b[5:1] != ver_q)
                n_progs = '0;
            ts_id = shift_q[15:0];
            ver_q = b[5:1];
        end
        else if (idx >= int'(IDX_ENTRY_START) && ((idx - 8) % 4) == int'(ENTRY_LAST_BYTE)
                 && idx + 2 <= int'(sec_len))
            store_program(shift_q[23:8], {shift_q[4:0], b});
        shift_q = {shift_q[15:0], b};
        if (idx >= int'(IDX_ENTRY_START) && idx == int'(sec_len) + 2)
        begin
            skipping = 1'b1;
            queue_report(ST_DONE, 13'(int'(sec_len) + 3), '0, dropped);
        end
        else
            byte_idx = 13'(idx + 1);
    endfunction

    task automatic send_item(input logic k, input logic f, input logic [7:0] b,
                             input logic [15:0] bl, input logic [15:0] pn);
        int gap;
        gap = sender_eager ? 0 : pick_gap(send_quiet);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        kind           <= k;
        first_byte     <= f;
        data_byte      <= b;
        buffer_length  <= bl;
        program_number <= pn;
        do
            @(posedge clk);
        while (full);
        mirror_transaction(k, f, b, bl, pn);
    endtask

    task automatic send_lookup(input logic [15:0] pn);
        send_item(1'b1, 1'($urandom), 8'($urandom), 16'($urandom), pn);
    endtask

    function automatic logic [15:0] pick_lookup_pn();
        if (n_progs > 0 && $urandom_range(0, 1) == 1)
            return pn_tab[$urandom_range(0, int'(n_progs) - 1)];
        if ($urandom_range(0, 7) == 0)
            return 16'd0;
        return 16'($urandom);
    endfunction

    function automatic octet_q build_section(logic [15:0] tsid, logic [4:0] ver, program_q progs,
                                             int pad);
        octet_q q;
        logic [11:0] sl;
        sl = 12'(9 + 4 * progs.size() + pad);
        q.push_back(8'h00);
        q.push_back({4'($urandom), sl[11:8]});
        q.push_back(sl[7:0]);
        q.push_back(tsid[15:8]);
        q.push_back(tsid[7:0]);
        q.push_back({2'($urandom), ver, 1'($urandom)});
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        foreach (progs[i])
        begin
            q.push_back(progs[i].pn[15:8]);
            q.push_back(progs[i].pn[7:0]);
            q.push_back({3'($urandom), progs[i].pid[12:8]});
            q.push_back(progs[i].pid[7:0]);
        end
        repeat (pad + 4) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic program_q random_programs(int n);
        program_q progs;
        program_t p;
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0: p.pn = 16'd0;
                1, 2, 3: p.pn = 16'($urandom_range(1, 12));
                default: p.pn = 16'($urandom);
            endcase
            if ($urandom_range(0, 4) == 0)
                p.pid = 13'($urandom);
            else
                p.pid = 13'($urandom_range(0, 23) * 341);
            progs.push_back(p);
        end
        return progs;
    endfunction

    task automatic send_section(input octet_q q, input logic [15:0] bl, input int lookup_at,
                                input int upto);
        int i;
        for (i = 0; i < upto; i++)
        begin
            if (i == lookup_at)
                send_lookup(pick_lookup_pn());
            send_item(1'b0, i == 0, q[i], bl, 16'($urandom));
        end
    endtask

    function automatic logic [15:0] random_buffer_length(int total);
        case ($urandom_range(0, 4))
            0: return 16'(total);
            1, 2: return 16'($urandom_range(total, total + 40));
            3: return 16'($urandom_range(total, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_random_section();
        octet_q q;
        int n;
        int pad;
        int total;
        logic [4:0] ver;
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        ver = ($urandom_range(0, 6) == 0) ? 5'($urandom) : ver_q;
        pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        q = build_section(16'($urandom), ver, random_programs(n), pad);
        total = q.size();
        send_section(q, random_buffer_length(total),
                     ($urandom_range(0, 2) == 0) ? $urandom_range(0, total - 1) : -1, total);
    endtask

    task automatic send_broken_section();
        octet_q q;
        int total;
        int sl;
        logic [15:0] bl;
        q = build_section(16'($urandom), ver_q, random_programs($urandom_range(0, 4)), 0);
        total = q.size();
        bl = random_buffer_length(total);
        case ($urandom_range(0, 4))
            0: bl = 16'($urandom_range(0, 7));
            1: q[0] = 8'($urandom_range(1, 255));
            2:
            begin
                sl = $urandom_range(0, 8);
                q[1] = {q[1][7:4], 4'h0};
                q[2] = 8'(sl);
            end
            3: bl = 16'($urandom_range(8, total - 1));
            default: total = $urandom_range(1, total - 1);
        endcase
        send_section(q, bl, -1, total);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_item(1'b0, $urandom_range(0, 9) == 0, 8'($urandom), 16'($urandom),
                      16'($urandom));
    endtask

    task automatic check_unopened_bytes();
        send_item(1'b0, 1'b0, 8'h00, 16'hFFFF, 16'h0000);
        send_item(1'b0, 1'b0, 8'hFF, 16'h0000, 16'hFFFF);
        send_item(1'b0, 1'b0, 8'h5A, 16'h00C0, 16'h1234);
        send_lookup(16'd0);
        send_lookup(16'hFFFF);
    endtask

    task automatic check_header_rejects();
        send_item(1'b0, 1'b1, 8'h00, 16'd7, 16'd0);
        send_item(1'b0, 1'b0, 8'h00, 16'd7, 16'd0);
        send_item(1'b0, 1'b1, 8'h00, 16'd0, 16'd0);
        send_item(1'b0, 1'b1, 8'hFF, 16'hFFFF, 16'd0);
        send_item(1'b0, 1'b0, 8'h00, 16'hFFFF, 16'd0);
        send_item(1'b0, 1'b1, 8'h00, 16'hFFFF, 16'd0);
        send_item(1'b0, 1'b0, 8'hF0, 16'hFFFF, 16'd0);
        send_item(1'b0, 1'b0, 8'd8, 16'hFFFF, 16'd0);
        send_item(1'b0, 1'b1, 8'h00, 16'd20, 16'd0);
        send_item(1'b0, 1'b0, 8'h00, 16'd20, 16'd0);
        send_item(1'b0, 1'b0, 8'd18, 16'd20, 16'd0);
    endtask

    task automatic check_smallest_section();
        octet_q q;
        program_q none;
        q = build_section(16'hFFFF, 5'd31, none, 0);
        send_section(q, 16'd12, -1, q.size());
    endtask

    task automatic check_program_entries();
        octet_q q;
        program_q progs;
        progs.push_back(program_t'{pn: 16'd1, pid: 13'h0100});
        progs.push_back(program_t'{pn: 16'd0, pid: 13'h0200});
        progs.push_back(program_t'{pn: 16'hFFFF, pid: 13'h1FFF});
        progs.push_back(program_t'{pn: 16'd2, pid: 13'h0100});
        q = build_section(16'h0000, 5'd31, progs, 3);
        send_section(q, 16'(q.size() + 7), 10, q.size());
        send_lookup(16'd2);
        send_lookup(16'd1);
        send_lookup(16'hFFFF);
        send_lookup(16'd0);
        progs.delete();
        progs.push_back(program_t'{pn: 16'd5, pid: 13'h0007});
        progs.push_back(program_t'{pn: 16'd6, pid: 13'h0008});
        q = build_section(16'h1234, 5'd31, progs, 0);
        send_section(q, 16'hFFFF, -1, 14);
        send_lookup(16'd5);
        progs.delete();
        q = build_section(16'h4321, 5'd3, progs, 1);
        send_section(q, 16'(q.size()), -1, q.size());
        send_lookup(16'd5);
    endtask

    task automatic check_random_traffic();
        int items_at_start;
        int reports_at_start;
        int pick;
        items_at_start   = live_items;
        reports_at_start = reports_made;
        while (live_items - items_at_start < 150 || reports_made - reports_at_start < 10)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_random_section();
            else if (pick < 75)
                send_lookup(pick_lookup_pn());
            else if (pick < 85)
                send_broken_section();
            else
                send_noise();
        end
    endtask

    task automatic check_table_overflow();
        octet_q q;
        program_q progs;
        int i;
        for (i = 0; i < 18; i++)
            progs.push_back(program_t'{pn: 16'($urandom_range(1, 65535)), pid: 13'(8000 + i)});
        q = build_section(16'($urandom), ver_q, progs, 0);
        send_section(q, 16'(q.size()), -1, q.size());
        send_lookup(progs[3].pn);
        send_lookup(progs[17].pn);
    endtask

    task automatic check_result_backlog();
        backlog_hold = 150;
        sender_eager = 1'b1;
        repeat (30) send_lookup(pick_lookup_pn());
        sender_eager = 1'b0;
    endtask

    task automatic check_longest_section();
        send_item(1'b0, 1'b1, 8'h00, 16'd4097, 16'd0);
        send_item(1'b0, 1'b0, 8'h3F, 16'd4097, 16'd0);
        send_item(1'b0, 1'b0, 8'hFF, 16'd4097, 16'd0);
        send_item(1'b0, 1'b1, 8'h00, 16'd4098, 16'd0);
        send_item(1'b0, 1'b0, 8'hBF, 16'd4098, 16'd0);
        send_item(1'b0, 1'b0, 8'hFF, 16'd4098, 16'd0);
        send_lookup(pick_lookup_pn());
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch in %s: got %0d, wanted %0d at %0t", what, got, want, $time);
    endtask

    task automatic check_pat_report();
        res_t want;
        if (pat_reports_due.size() == 0)
        begin
            note_mismatch("unsolicited result status", int'(status), -1);
            return;
        end
        want = pat_reports_due.pop_front();
        if (status !== 3'(want.status))
            note_mismatch("status", int'(status), int'(want.status));
        if (consumed_length !== want.consumed)
            note_mismatch("consumed_length", int'(consumed_length), int'(want.consumed));
        if (stream_id !== want.stream_id)
            note_mismatch("stream_id", int'(stream_id), int'(want.stream_id));
        if (version !== want.version)
            note_mismatch("version", int'(version), int'(want.version));
        if (program_count !== want.count)
            note_mismatch("program_count", int'(program_count), int'(want.count));
        if (found_pid !== want.pid)
            note_mismatch("found_pid", int'(found_pid), int'(want.pid));
        if (table_full !== want.full)
            note_mismatch("table_full", int'(table_full), int'(want.full));
    endtask

    initial
    begin : result_drain
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (backlog_hold > 0)
            begin
                pop <= 1'b0;
                repeat (backlog_hold) @(posedge clk);
                backlog_hold = 0;
            end
            gap = pick_gap(recv_quiet);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_pat_report();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL ts_program_association_parser_core");
                $finish;
            end
        end
    end

    initial
    begin
        push           <= 1'b0;
        kind           <= 1'b0;
        first_byte     <= 1'b0;
        data_byte      <= 8'h00;
        buffer_length  <= 16'h0000;
        program_number <= 16'h0000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_unopened_bytes();
        check_header_rejects();
        check_smallest_section();
        check_program_entries();
        check_random_traffic();
        check_table_overflow();
        check_result_backlog();
        check_longest_section();
        push <= 1'b0;
        while (pat_reports_due.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (mismatches == 0)
            $display("PASS ts_program_association_parser_core");
        else
            $display("FAIL ts_program_association_parser_core");
        $finish;
    end

endmodule
